/* src/vts_pkg.sv */
package vts_pkg;

   localparam logic [2:0] CSR_WIDTH_IN_USE  = 3'd0;
   localparam logic [2:0] CSR_HEIGHT_IN_USE = 3'd1;
   localparam logic [2:0] CSR_DEPTH_IN_USE  = 3'd2;
   localparam logic [2:0] CSR_INV_SCALE_X   = 3'd3;
   localparam logic [2:0] CSR_INV_SCALE_Y   = 3'd4;
   localparam logic [2:0] CSR_INV_SCALE_Z   = 3'd5;

   localparam logic [2:0] BLEND_LAST = 3'd6;

   typedef struct packed {
      logic       wr_en;
      logic       start;
      logic       scale;
      logic       axis;
      logic       fetch_en;
      logic [2:0] fetch_idx;
      logic       cap_en;
      logic [2:0] cap_idx;
      logic       blend_en;
      logic [2:0] blend_step;
   } vts_cmd_type;

   typedef struct packed {
      logic out_blocked;
   } vts_sts_type;

   // Linear blend a*(1-f) + b*f with f in Q0.16, result scaled by 2^16.
   function automatic logic [47:0] vts_lerp(input logic [31:0] a, input logic [31:0] b,
                                            input logic [15:0] f);
      logic signed [32:0] d;
      logic signed [49:0] p;
      logic signed [49:0] s;
      d = $signed({1'b0, b}) - $signed({1'b0, a});
      p = d * $signed({1'b0, f});
      s = $signed({2'b00, a, 16'h0000}) + p;
      return s[47:0];
   endfunction

endpackage

/* src/vts_ctrl.sv */
module vts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_stall,
   output vts_pkg::vts_cmd_type cmd,
   input  vts_pkg::vts_sts_type sts
);
   import vts_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCALE = 5'b00010,
      ST_AXIS  = 5'b00100,
      ST_FETCH = 5'b01000,
      ST_BLEND = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      cmd            = '0;
      req_stall      = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.wr_en = req_valid & ~req_action;
            cmd.start = req_valid & req_action;
            if (req_valid && req_action) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_AXIS;
         end
         ST_AXIS: begin
            cmd.axis = 1'b1;
            cnt_in   = 4'd0;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch_en  = ~cnt_ff[3];
            cmd.fetch_idx = cnt_ff[2:0];
            cmd.cap_en    = (cnt_ff != 4'd0);
            cmd.cap_idx   = 3'(cnt_ff - 4'd1);
            if (cnt_ff[3]) begin
               cnt_in   = 4'd0;
               state_in = ST_BLEND;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_BLEND: begin
            cmd.blend_step = cnt_ff[2:0];
            cmd.blend_en   = (cnt_ff[2:0] != BLEND_LAST) | ~sts.out_blocked;
            if (cmd.blend_en) begin
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff[2:0] == BLEND_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 4'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_fetch_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> cnt_ff <= 4'd8)
      else $error("fetch counter out of range");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.blend_en && cmd.blend_step == BLEND_LAST |-> !sts.out_blocked)
      else $error("result loaded while output is blocked");
   a_sample_start: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state_ff == ST_SCALE)
      else $error("sample request did not start");
   a_scale_axis: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCALE |=> state_ff == ST_AXIS)
      else $error("scale stage not followed by axis stage");

endmodule

/* src/vts_dp.sv */
module vts_dp #(
   parameter int MAX_DIM    = 64,
   parameter int VOXEL_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  vts_pkg::vts_cmd_type cmd,
   output vts_pkg::vts_sts_type sts,
   input  logic                 csr_valid,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data,
   input  logic [5:0]           req_write_x,
   input  logic [5:0]           req_write_y,
   input  logic [5:0]           req_write_z,
   input  logic [7:0]           req_write_value,
   input  logic signed [19:0]   req_pos_x,
   input  logic signed [19:0]   req_pos_y,
   input  logic signed [19:0]   req_pos_z,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [15:0]          rsp_sample_value
);
   import vts_pkg::*;

   localparam int AW    = $clog2(MAX_DIM);
   localparam int DEPTH = 1 << (3 * AW);
   localparam logic [8:0] DIM9  = 9'(MAX_DIM);
   localparam logic [8:0] DIMM1 = 9'(MAX_DIM - 1);

   logic [VOXEL_BITS-1:0] mem [0:DEPTH-1];
   logic [VOXEL_BITS-1:0] rd_ff;

   logic [6:0]  ext_ff [3];
   logic [15:0] inv_ff [3];
   logic signed [19:0] pos_ff [3];
   logic signed [36:0] u_ff [3];
   logic [AW-1:0] lo_ff [3], hi_ff [3];
   logic [15:0]   frac_ff [3];
   logic [AW-1:0] lo_in [3], hi_in [3];
   logic [15:0]   frac_in [3];
   logic [VOXEL_BITS-1:0] vox_ff [8];
   logic [31:0] xl_ff [4];
   logic [31:0] yl_ff [2];
   logic        out_valid_ff;
   logic [15:0] out_value_ff;

   logic [8:0]  wx9, wy9, wz9;
   logic        wr_ok;
   logic [3*AW-1:0] waddr, raddr;
   logic [31:0] la, lb;
   logic [15:0] lf;
   logic [47:0] lres;
   logic [48:0] yround;
   logic [48:0] zround;

   assign wx9 = {3'b000, req_write_x};
   assign wy9 = {3'b000, req_write_y};
   assign wz9 = {3'b000, req_write_z};
   assign wr_ok = (wx9 < DIM9) && (wy9 < DIM9) && (wz9 < DIM9);
   assign waddr = {wz9[AW-1:0], wy9[AW-1:0], wx9[AW-1:0]};
   assign raddr = {cmd.fetch_idx[2] ? hi_ff[2] : lo_ff[2],
                   cmd.fetch_idx[1] ? hi_ff[1] : lo_ff[1],
                   cmd.fetch_idx[0] ? hi_ff[0] : lo_ff[0]};

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_ok) begin
         mem[waddr] <= VOXEL_BITS'(req_write_value);
      end
      if (cmd.fetch_en) begin
         rd_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff[0] <= 7'd64;
         ext_ff[1] <= 7'd64;
         ext_ff[2] <= 7'd64;
         inv_ff[0] <= 16'd256;
         inv_ff[1] <= 16'd256;
         inv_ff[2] <= 16'd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH_IN_USE:  ext_ff[0] <= csr_data[6:0];
            CSR_HEIGHT_IN_USE: ext_ff[1] <= csr_data[6:0];
            CSR_DEPTH_IN_USE:  ext_ff[2] <= csr_data[6:0];
            CSR_INV_SCALE_X:   inv_ff[0] <= csr_data;
            CSR_INV_SCALE_Y:   inv_ff[1] <= csr_data;
            CSR_INV_SCALE_Z:   inv_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [8:0]         top;
      logic signed [21:0] fl;
      logic signed [21:0] ce;
      logic [15:0]        f;
      logic [8:0]         cl;
      logic [8:0]         ch;
      for (int i = 0; i < 3; i++) begin
         if (ext_ff[i] == 7'd0) begin
            top = 9'd0;
         end else if ({2'b00, ext_ff[i]} > DIM9) begin
            top = DIMM1;
         end else begin
            top = {2'b00, ext_ff[i]} - 9'd1;
         end
         fl = 22'($signed(u_ff[i][36:16]));
         f  = u_ff[i][15:0];
         ce = fl + ((f != 16'd0) ? 22'sd1 : 22'sd0);
         if (fl < 0) begin
            cl = 9'd0;
         end else if (fl > $signed({13'd0, top})) begin
            cl = top;
         end else begin
            cl = fl[8:0];
         end
         if (ce < 0) begin
            ch = 9'd0;
         end else if (ce > $signed({13'd0, top})) begin
            ch = top;
         end else begin
            ch = ce[8:0];
         end
         lo_in[i]   = cl[AW-1:0];
         hi_in[i]   = ch[AW-1:0];
         frac_in[i] = (cl == ch) ? 16'd0 : f;
      end
   end

   always_comb begin
      la = 32'(vox_ff[0]);
      lb = 32'(vox_ff[1]);
      lf = frac_ff[0];
      unique case (cmd.blend_step)
         3'd0: begin
            la = 32'(vox_ff[0]);
            lb = 32'(vox_ff[1]);
         end
         3'd1: begin
            la = 32'(vox_ff[2]);
            lb = 32'(vox_ff[3]);
         end
         3'd2: begin
            la = 32'(vox_ff[4]);
            lb = 32'(vox_ff[5]);
         end
         3'd3: begin
            la = 32'(vox_ff[6]);
            lb = 32'(vox_ff[7]);
         end
         3'd4: begin
            la = xl_ff[0];
            lb = xl_ff[1];
            lf = frac_ff[1];
         end
         3'd5: begin
            la = xl_ff[2];
            lb = xl_ff[3];
            lf = frac_ff[1];
         end
         default: begin
            la = yl_ff[0];
            lb = yl_ff[1];
            lf = frac_ff[2];
         end
      endcase
   end

   assign lres   = vts_lerp(la, lb, lf);
   assign yround = {1'b0, lres} + 49'd32768;
   assign zround = {1'b0, lres} + 49'h800000;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
      end
      if (cmd.scale) begin
         for (int i = 0; i < 3; i++) begin
            u_ff[i] <= pos_ff[i] * $signed({1'b0, inv_ff[i]}) - 37'sd32768;
         end
      end
      if (cmd.axis) begin
         for (int i = 0; i < 3; i++) begin
            lo_ff[i]   <= lo_in[i];
            hi_ff[i]   <= hi_in[i];
            frac_ff[i] <= frac_in[i];
         end
      end
      if (cmd.cap_en) begin
         vox_ff[cmd.cap_idx] <= rd_ff;
      end
      if (cmd.blend_en) begin
         unique case (cmd.blend_step)
            3'd0, 3'd1, 3'd2, 3'd3: xl_ff[cmd.blend_step[1:0]] <= lres[31:0];
            3'd4: yl_ff[0] <= yround[47:16];
            3'd5: yl_ff[1] <= yround[47:16];
            default: begin
               out_value_ff <= (zround[48:40] != 9'd0) ? 16'hFFFF : zround[39:24];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.blend_en && cmd.blend_step == BLEND_LAST) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign sts.out_blocked  = out_valid_ff & rsp_stall;
   assign rsp_valid        = out_valid_ff;
   assign rsp_sample_value = out_value_ff;

endmodule

/* src/volume_trilinear_sampler.sv */
// Voxel volume sampler. A write request stores one voxel and gives no response. A
// sample request holds the input from the cycle in which it is accepted until it
// is finished: the scale and axis states turn the position into clamped corner
// indices and fractions, the fetch state reads the eight corner voxels one after
// another from the voxel memory, and the blend state runs seven blends through one
// shared interpolation multiplier. The last blend waits while an earlier response
// is still stalled in the output register. A new request is taken as soon as the
// previous one is finished, even while its response still waits in the output
// register. Voxels must be written before a sample reads them; the memory has no
// reset.
module volume_trilinear_sampler #(
   parameter int MAX_DIM    = 64,
   parameter int VOXEL_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [5:0]         req_write_x,
   input  logic [5:0]         req_write_y,
   input  logic [5:0]         req_write_z,
   input  logic [7:0]         req_write_value,
   input  logic signed [19:0] req_pos_x,
   input  logic signed [19:0] req_pos_y,
   input  logic signed [19:0] req_pos_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_sample_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import vts_pkg::*;

   vts_cmd_type cmd;
   vts_sts_type sts;

   assign csr_ready = 1'b1;

   vts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   vts_dp #(
      .MAX_DIM    (MAX_DIM),
      .VOXEL_BITS (VOXEL_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_write_x      (req_write_x),
      .req_write_y      (req_write_y),
      .req_write_z      (req_write_z),
      .req_write_value  (req_write_value),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_sample_value (rsp_sample_value)
   );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import vts_pkg::*;

   localparam int DIM = 64;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE = 40;

   typedef struct {
      logic              action;
      logic [5:0]        wx;
      logic [5:0]        wy;
      logic [5:0]        wz;
      logic [7:0]        wv;
      logic signed [19:0] px;
      logic signed [19:0] py;
      logic signed [19:0] pz;
   } voxel_request_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_action = 1'b0;
   logic [5:0]         req_write_x = '0;
   logic [5:0]         req_write_y = '0;
   logic [5:0]         req_write_z = '0;
   logic [7:0]         req_write_value = '0;
   logic signed [19:0] req_pos_x = '0;
   logic signed [19:0] req_pos_y = '0;
   logic signed [19:0] req_pos_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic [15:0]        rsp_sample_value;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = CSR_WIDTH_IN_USE;
   logic [15:0]        csr_data = '0;

   voxel_request_type pend_requests[$];
   logic [15:0]    density_due[$];
   logic [7:0]     voxel_mirror[DIM*DIM*DIM];
   bit             voxel_filled[DIM*DIM*DIM];
   logic [6:0]     ext_x = 7'd64, ext_y = 7'd64, ext_z = 7'd64;
   logic [15:0]    recip_x = 16'd256, recip_y = 16'd256, recip_z = 16'd256;
   int             fail_count = 0;
   int             samples_taken = 0;
   int             idle_cycles = 0;
   int             burst_left = 0;
   int             gap_left = 0;
   int             stall_mode = 0;
   int             mode_cycles = 0;
   bit             hold_on = 1'b0;
   bit             hold_done = 1'b0;
   int             hold_count = 0;

   volume_trilinear_sampler DUT (.*);

   always #4 clock = ~clock;

   function automatic int clip_extent(input logic [6:0] r);
      if (r < 1) return 1;
      if (r > DIM) return DIM;
      return r;
   endfunction

   function automatic void axis_span(input logic signed [19:0] p, input logic [15:0] inv,
                                     input logic [6:0] ext_reg, output int lo, output int hi,
                                     output longint frac);
      longint u, fl, ce;
      int top;
      u = longint'(p) * longint'(inv) - 32768;
      fl = u >>> 16;
      frac = u & 64'hFFFF;
      ce = fl + (frac != 0 ? 1 : 0);
      top = clip_extent(ext_reg) - 1;
      if (fl < 0) fl = 0;
      if (fl > top) fl = top;
      if (ce < 0) ce = 0;
      if (ce > top) ce = top;
      lo = int'(fl);
      hi = int'(ce);
      if (lo == hi) frac = 0;
   endfunction

   function automatic int voxel_addr(input int x, input int y, input int z);
      return x + y * DIM + z * DIM * DIM;
   endfunction

   function automatic longint mix(input longint a, input longint b, input longint f);
      return a * (65536 - f) + b * f;
   endfunction

   function automatic longint vox(input int x, input int y, input int z);
      return voxel_mirror[voxel_addr(x, y, z)];
   endfunction

   function automatic logic [15:0] blended_density(input voxel_request_type r);
      int x0, x1, y0, y1, z0, z1;
      longint fx, fy, fz, c00, c10, c01, c11, c0, c1, c, res;
      axis_span(r.px, recip_x, ext_x, x0, x1, fx);
      axis_span(r.py, recip_y, ext_y, y0, y1, fy);
      axis_span(r.pz, recip_z, ext_z, z0, z1, fz);
      c00 = mix(vox(x0, y0, z0), vox(x1, y0, z0), fx);
      c10 = mix(vox(x0, y1, z0), vox(x1, y1, z0), fx);
      c01 = mix(vox(x0, y0, z1), vox(x1, y0, z1), fx);
      c11 = mix(vox(x0, y1, z1), vox(x1, y1, z1), fx);
      c0 = (mix(c00, c10, fy) + 32768) >> 16;
      c1 = (mix(c01, c11, fy) + 32768) >> 16;
      c = mix(c0, c1, fz);
      res = (c + (longint'(1) << 23)) >> 24;
      if (res > 65535) res = 65535;
      return res[15:0];
   endfunction

   function automatic void add_write(input int x, input int y, input int z, input int v);
      voxel_request_type r;
      r.action = 1'b0;
      r.wx = 6'(x);
      r.wy = 6'(y);
      r.wz = 6'(z);
      r.wv = 8'(v);
      r.px = 20'($urandom);
      r.py = 20'($urandom);
      r.pz = 20'($urandom);
      voxel_filled[voxel_addr(x, y, z)] = 1'b1;
      pend_requests.push_back(r);
   endfunction

   // Corners that the sample will read are written first if they hold no data yet.
   function automatic void add_sample(input logic signed [19:0] px, input logic signed [19:0] py,
                                      input logic signed [19:0] pz);
      voxel_request_type r;
      int xs[2], ys[2], zs[2];
      longint f;
      axis_span(px, recip_x, ext_x, xs[0], xs[1], f);
      axis_span(py, recip_y, ext_y, ys[0], ys[1], f);
      axis_span(pz, recip_z, ext_z, zs[0], zs[1], f);
      foreach (xs[i])
         foreach (ys[j])
            foreach (zs[k])
               if (!voxel_filled[voxel_addr(xs[i], ys[j], zs[k])])
                  add_write(xs[i], ys[j], zs[k], $urandom_range(0, 255));
      r.action = 1'b1;
      r.wx = 6'($urandom);
      r.wy = 6'($urandom);
      r.wz = 6'($urandom);
      r.wv = 8'($urandom);
      r.px = px;
      r.py = py;
      r.pz = pz;
      pend_requests.push_back(r);
   endfunction

   function automatic logic signed [19:0] pick_pos(input logic [15:0] inv, input logic [6:0] e);
      longint span;
      if ($urandom_range(0, 9) < 3) return 20'($urandom);
      if (inv == 0) return 20'($urandom);
      span = (longint'(clip_extent(e)) * 65536) / inv + 2;
      if (span > 524287) span = 524287;
      if ($urandom_range(0, 9) == 0) return 20'(-int'($urandom_range(0, 600)));
      return 20'($urandom_range(0, int'(span)));
   endfunction

   function automatic void random_phase(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0)
            add_write($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 255));
         else
            add_sample(pick_pos(recip_x, ext_x), pick_pos(recip_y, ext_y),
                       pick_pos(recip_z, ext_z));
      end
   endfunction

   task automatic set_reg(input logic [2:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_WIDTH_IN_USE:  ext_x = value[6:0];
         CSR_HEIGHT_IN_USE: ext_y = value[6:0];
         CSR_DEPTH_IN_USE:  ext_z = value[6:0];
         CSR_INV_SCALE_X:   recip_x = value;
         CSR_INV_SCALE_Y:   recip_y = value;
         CSR_INV_SCALE_Z:   recip_z = value;
         default: ;
      endcase
   endtask

   task automatic set_volume(input int w, input int h, input int d,
                             input int ix, input int iy, input int iz);
      set_reg(CSR_WIDTH_IN_USE, 16'(w));
      set_reg(CSR_HEIGHT_IN_USE, 16'(h));
      set_reg(CSR_DEPTH_IN_USE, 16'(d));
      set_reg(CSR_INV_SCALE_X, 16'(ix));
      set_reg(CSR_INV_SCALE_Y, 16'(iy));
      set_reg(CSR_INV_SCALE_Z, 16'(iz));
   endtask

   task automatic drain;
      while (pend_requests.size() != 0 || req_valid || density_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      voxel_request_type r;
      bit next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            r.action = req_action;
            r.wx = req_write_x;
            r.wy = req_write_y;
            r.wz = req_write_z;
            r.wv = req_write_value;
            r.px = req_pos_x;
            r.py = req_pos_y;
            r.pz = req_pos_z;
            if (r.action)
               density_due.push_back(blended_density(r));
            else
               voxel_mirror[voxel_addr(r.wx, r.wy, r.wz)] = r.wv;
            next_valid = 1'b0;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pend_requests.size() != 0) begin
               r = pend_requests.pop_front();
               next_valid = 1'b1;
               req_action <= r.action;
               req_write_x <= r.wx;
               req_write_y <= r.wy;
               req_write_z <= r.wz;
               req_write_value <= r.wv;
               req_pos_x <= r.px;
               req_pos_y <= r.py;
               req_pos_z <= r.pz;
            end
         end
         req_valid <= next_valid;
      end
   end

   // Long hold-off on the response side, once, so that the sampler backs up.
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && !hold_on && samples_taken == 10) begin
            hold_on <= 1'b1;
            hold_count <= 0;
         end else if (hold_on) begin
            hold_count <= hold_count + 1;
            if (hold_count == 400) begin
               hold_on <= 1'b0;
               hold_done <= 1'b1;
            end
         end
      end
   end

   // Response monitor with its own stall pattern.
   always @(posedge clock) begin
      logic [15:0] want;
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            samples_taken <= samples_taken + 1;
            if (density_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0d", $time,
                        rsp_sample_value);
               fail_count++;
            end else begin
               want = density_due.pop_front();
               if (rsp_sample_value !== want) begin
                  $display("%0t: sample_value mismatch, expected %0d, actual %0d", $time,
                           want, rsp_sample_value);
                  fail_count++;
               end
            end
         end
         if (mode_cycles == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_cycles = $urandom_range(20, 120);
         end else begin
            mode_cycles--;
         end
         case (stall_mode)
            0: rsp_stall <= hold_on;
            1: rsp_stall <= hold_on || ($urandom_range(0, 9) < 3);
            2: rsp_stall <= hold_on || mode_cycles[0];
            default: rsp_stall <= hold_on || ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("volume_trilinear_sampler verification failed");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      add_write(0, 0, 0, 0);
      add_write(63, 63, 63, 255);
      add_write(1, 0, 0, 255);
      add_write(0, 1, 0, 128);
      add_write(0, 0, 1, 77);
      add_sample(20'sd128, 20'sd128, 20'sd128);
      add_sample(20'sd256, 20'sd256, 20'sd256);
      add_sample(20'sd192, 20'sd200, 20'sd300);
      add_sample(20'sh80000, 20'sh80000, 20'sh80000);
      add_sample(20'sd524287, 20'sd524287, 20'sd524287);
      add_sample(20'sd0, 20'sd0, 20'sd0);
      add_sample(20'sd16256, 20'sd16256, 20'sd16256);
      add_sample(20'sd16383, 20'sd100, -20'sd1);
      random_phase(20);
      drain();

      set_volume(1, 1, 1, 256, 256, 256);
      add_sample(20'sd300, -20'sd5, 20'sd524287);
      random_phase(20);
      drain();

      set_volume(64, 64, 64, 65535, 65535, 65535);
      add_sample(20'sd16383, 20'sd8000, 20'sd1);
      add_sample(20'sh80000, 20'sd524287, 20'sd128);
      random_phase(15);
      drain();

      set_volume(0, 127, 5, 0, 1, 512);
      add_sample(20'sd524287, 20'sd524287, 20'sd300);
      random_phase(25);
      drain();

      set_volume($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
                 $urandom_range(64, 1024), $urandom_range(64, 1024), $urandom_range(1, 65535));
      random_phase(15);
      drain();

      set_volume(64, 64, 64, 256, 256, 256);
      random_phase(15);
      drain();

      if (fail_count == 0)
         $display("volume_trilinear_sampler verification clean");
      else
         $display("volume_trilinear_sampler verification failed");
      $finish;
   end

endmodule
